FILE: src/gbpw_pkg.sv
`timescale 1ns / 1ps

package gbpw_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int BYTE_W         = 8;
	localparam int PITCH_W        = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int SUB_W          = 3;   // bit position within a byte

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_MODE     = 3'd0,
		REG_BOX_LEFT       = 3'd1,
		REG_BOX_RIGHT_END  = 3'd2,
		REG_BOX_TOP        = 3'd3,
		REG_BOX_BOTTOM_END = 3'd4,
		REG_ROW_PITCH      = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		DEPTH_1BPP = 1'b0,
		DEPTH_8BPP = 1'b1
	} depth_t;

endpackage

FILE: src/glyph_bitmap_to_pixel_writes_core.sv
`timescale 1ns / 1ps

// Glyph blitter: takes a glyph bitmap one byte per request on s_axis and
// gives one foreground pixel write (x, y) per request on m_axis for every
// set pixel that lands inside the glyph box.
// cfg: register writes (index, data), always ready; write only while idle.
//   0 depth_mode, 1 box_left, 2 box_right_end, 3 box_top,
//   4 box_bottom_end, 5 row_pitch.
// s_axis: tdata = bitmap_byte, tuser = glyph_start (clears row/column walk).
// m_axis: tdata = {pixel_y, pixel_x}, tlast = last pixel of this byte.
// A taken byte is held in the emitter, whose pixels move to the output register.
// Throughput: the emitter hands out one pixel per cycle while m_axis is not
// stalled, so a byte holds it until its set pixels in the box (1 to 8) are
// out; bytes that give no pixel go at one per cycle while it is empty. The next
// byte is taken in the cycle the current byte's last pixel enters the output register.
// Reset: glyph walk idle until a glyph start, registers at their defaults
// (row_pitch 1, rest 0), no pixel pending.
// Stall: when m_axis_tready is low the output register holds its pixel,
// the emitter holds the rest of its byte and s_axis_tready drops as soon
// as the emitter holds a byte.
module glyph_bitmap_to_pixel_writes_core #(
	parameter int COORD_BITS = gbpw_pkg::COORD_BITS_DEF,
	// derived, leave at default
	parameter int CFG_W = (COORD_BITS + 1 > gbpw_pkg::PITCH_W) ?
		COORD_BITS + 1 : gbpw_pkg::PITCH_W,
	parameter int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	// bitmap bytes in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [gbpw_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] bitmap_byte
	input  logic                            s_axis_tuser,  // [0] glyph_start
	// pixel writes out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [OUT_W-1:0]                m_axis_tdata,  // pixel_x, then pixel_y
	output logic                            m_axis_tlast   // last_of_byte
);
	import gbpw_pkg::*;

	localparam int CNT_W = CFG_W;

	logic                  accept;
	logic                  fire;
	logic [BYTE_W-1:0]     pix_mask;
	logic [COORD_BITS-1:0] x_base;
	logic [COORD_BITS-1:0] y_row;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;

	// Walk state and per-byte pixel mask.
	gbpw_scan #(
		.COORD_BITS (COORD_BITS),
		.CNT_W      (CNT_W),
		.CFG_W      (CFG_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.bitmap_byte (s_axis_tdata),
		.glyph_start (s_axis_tuser),
		.fire        (fire),
		.pix_mask    (pix_mask),
		.x_base      (x_base),
		.y_row       (y_row)
	);

	// Hold the byte's pixels and hand them out one per cycle while m_axis is not stalled.
	gbpw_emit #(
		.COORD_BITS (COORD_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.pix_mask     (pix_mask),
		.x_base       (x_base),
		.y_row        (y_row),
		.take_ready   (s_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_byte (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

FILE: src/gbpw_scan.sv
`timescale 1ns / 1ps

module gbpw_scan #(
	parameter int COORD_BITS = gbpw_pkg::COORD_BITS_DEF,
	parameter int CNT_W      = 13,
	parameter int CFG_W      = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [gbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	input  logic                            accept,
	input  logic [gbpw_pkg::BYTE_W-1:0]     bitmap_byte,
	input  logic                            glyph_start,
	output logic                            fire,
	output logic [gbpw_pkg::BYTE_W-1:0]     pix_mask,
	output logic [COORD_BITS-1:0]           x_base,
	output logic [COORD_BITS-1:0]           y_row
);
	import gbpw_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int CW = CNT_W + SUB_W;

	depth_t              depth_q;
	logic [CB-1:0]       left_q;
	logic [CB:0]         right_end_q;
	logic [CB-1:0]       top_q;
	logic [CB:0]         bottom_end_q;
	logic [PITCH_W-1:0]  pitch_q;

	logic [CB-1:0]       row_q;
	logic [CNT_W-1:0]    col_q;
	logic                fin_q;

	logic [CB-1:0]       cur_row;
	logic [CNT_W-1:0]    cur_col;
	logic                cur_fin;
	logic [CB:0]         right_c;
	logic [CB:0]         bottom_c;
	logic                empty_box;
	logic [CB:0]         width;
	logic [CB:0]         height;
	logic [PITCH_W-1:0]  pitch;
	logic [CNT_W-1:0]    row_len;
	logic [CNT_W-1:0]    col_n;
	logic [CB:0]         row_n;
	logic [CW-1:0]       width_ext;
	logic [CW-1:0]       col_pos;
	logic [CW-1:0]       bit_col;
	logic                active;
	logic [BYTE_W-1:0]   mask;
	logic [CB-1:0]       row_d;
	logic [CNT_W-1:0]    col_d;
	logic                fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= DEPTH_1BPP;
			left_q       <= '0;
			right_end_q  <= '0;
			top_q        <= '0;
			bottom_end_q <= '0;
			pitch_q      <= PITCH_W'(1);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEPTH_MODE:     depth_q      <= depth_t'(cfg_data[0]);
				REG_BOX_LEFT:       left_q       <= cfg_data[CB-1:0];
				REG_BOX_RIGHT_END:  right_end_q  <= cfg_data[CB:0];
				REG_BOX_TOP:        top_q        <= cfg_data[CB-1:0];
				REG_BOX_BOTTOM_END: bottom_end_q <= cfg_data[CB:0];
				REG_ROW_PITCH:      pitch_q      <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// A glyph start clears the walk before the byte is used.
	assign cur_row = glyph_start ? '0 : row_q;
	assign cur_col = glyph_start ? '0 : col_q;
	assign cur_fin = glyph_start ? 1'b0 : fin_q;

	// Saturate box ends to the screen size.
	assign right_c   = right_end_q[CB] ? {1'b1, {CB{1'b0}}} : right_end_q;
	assign bottom_c  = bottom_end_q[CB] ? {1'b1, {CB{1'b0}}} : bottom_end_q;
	assign empty_box = (right_c <= {1'b0, left_q}) || (bottom_c <= {1'b0, top_q});
	assign width     = right_c - {1'b0, left_q};
	assign height    = bottom_c - {1'b0, top_q};
	assign pitch     = (pitch_q == '0) ? PITCH_W'(1) : pitch_q;
	assign row_len   = (depth_q == DEPTH_8BPP) ? CNT_W'(width) : CNT_W'(pitch);
	assign col_n     = cur_col + CNT_W'(1);
	assign row_n     = {1'b0, cur_row} + (CB+1)'(1);
	assign width_ext = CW'(width);
	assign active    = !cur_fin && !empty_box;

	assign col_pos = (depth_q == DEPTH_8BPP) ? CW'(cur_col) : {cur_col, {SUB_W{1'b0}}};

	always_comb begin
		mask    = '0;
		bit_col = '0;
		if (depth_q == DEPTH_8BPP) begin
			if ((bitmap_byte != '0) && (CW'(cur_col) < width_ext))
				mask[BYTE_W-1] = 1'b1;
		end else begin
			for (int k = 0; k < BYTE_W; k++) begin
				bit_col = {cur_col, SUB_W'(k)};
				mask[BYTE_W-1-k] = bitmap_byte[BYTE_W-1-k] && (bit_col < width_ext);
			end
		end
	end

	assign fire     = accept && active && (mask != '0);
	assign pix_mask = mask;
	assign x_base   = left_q + CB'(col_pos);
	assign y_row    = top_q + cur_row;

	// Next walk position after this byte.
	always_comb begin
		row_d = cur_row;
		col_d = cur_col;
		fin_d = cur_fin;
		if (!cur_fin) begin
			if (empty_box) begin
				fin_d = 1'b1;
			end else if (col_n >= row_len) begin
				col_d = '0;
				if (row_n >= height)
					fin_d = 1'b1;
				else
					row_d = CB'(row_n);
			end else begin
				col_d = col_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			fin_q <= 1'b1;
		end else if (accept) begin
			row_q <= row_d;
			col_q <= col_d;
			fin_q <= fin_d;
		end
	end

endmodule

FILE: src/gbpw_emit.sv
`timescale 1ns / 1ps

module gbpw_emit #(
	parameter int COORD_BITS = gbpw_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [gbpw_pkg::BYTE_W-1:0]  pix_mask,
	input  logic [COORD_BITS-1:0]        x_base,
	input  logic [COORD_BITS-1:0]        y_row,
	output logic                         take_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic                         last_of_byte
);
	import gbpw_pkg::*;

	localparam int CB = COORD_BITS;

	logic                valid_s1;
	logic [BYTE_W-1:0]   mask_s1;
	logic [CB-1:0]       xbase_s1;
	logic [CB-1:0]       y_s1;

	logic                valid_q;
	logic [CB-1:0]       x_q;
	logic [CB-1:0]       y_q;
	logic                last_q;

	logic                out_load;
	logic                take;
	logic                drain;
	logic [SUB_W-1:0]    lead;
	logic                found;
	logic [BYTE_W-1:0]   rest;

	// Pick the leftmost remaining pixel (most significant bit first).
	always_comb begin
		lead  = '0;
		found = 1'b0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (!found && mask_s1[BYTE_W-1-i]) begin
				lead  = SUB_W'(i);
				found = 1'b1;
			end
		end
	end

	assign rest       = mask_s1 & ~({1'b1, {(BYTE_W-1){1'b0}}} >> lead);
	assign out_load   = !valid_q || out_ready;
	assign take       = valid_s1 && out_load;
	assign drain      = take && (rest == '0);
	assign take_ready = !valid_s1 || drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_s1  <= pix_mask;
			xbase_s1 <= x_base;
			y_s1     <= y_row;
		end else if (take) begin
			mask_s1  <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (out_load)
			valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q    <= xbase_s1 + CB'(lead);
			y_q    <= y_s1;
			last_q <= (rest == '0);
		end
	end

	assign out_valid    = valid_q;
	assign pixel_x      = x_q;
	assign pixel_y      = y_q;
	assign last_of_byte = last_q;

endmodule

FILE: src/gbpw_checker.sv
`timescale 1ns / 1ps

module gbpw_checker #(
	parameter int COORD_BITS = gbpw_pkg::COORD_BITS_DEF,
	parameter int OUT_W      = 24
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata,
	input logic              m_axis_tlast
);

	localparam int CB = COORD_BITS;

	// Output holds while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("pixel write changed while stalled");

	// A byte's remaining pixels block new bytes while the output stalls.
	a_mid_byte_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("byte taken while previous byte still has pixels");

	// Pixels of one byte follow back to back on the same row.
	a_byte_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid &&
			(m_axis_tdata[2*CB-1:CB] == $past(m_axis_tdata[2*CB-1:CB])))
		else $error("pixel burst of a byte broken");

	// Nothing pending right after reset.
	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("pixel write valid out of reset");

endmodule

bind glyph_bitmap_to_pixel_writes_core gbpw_checker #(
	.COORD_BITS (COORD_BITS),
	.OUT_W      (OUT_W)
) u_gbpw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import gbpw_pkg::*;

	localparam int CB          = COORD_BITS_DEF;
	localparam int CFG_W       = (CB + 1 > PITCH_W) ? CB + 1 : PITCH_W;
	localparam int OUT_W       = ((2 * CB + 7) / 8) * 8;
	localparam int SCREEN      = 1 << CB;
	localparam int CMASK       = SCREEN - 1;
	localparam int ROW_MASK    = 'hFFF;
	localparam int COL_MASK    = 'h1FFF;
	localparam int SETTLE      = 4;       // settle wait for a pixel-less byte still in flight
	localparam int TAIL        = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 100;     // drawn bytes per idling phase
	localparam int NO_TYPED    = -1;      // table row is checked against the predictor

	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic          last;
	} pixel_t;

	typedef enum {ROW_CFG, ROW_BYTE} row_kind_t;

	// One directed step: a register write, or a bitmap byte with either a typed
	// outcome (none, or one pixel that ends the byte) or NO_TYPED.
	typedef struct {
		row_kind_t kind;
		cfg_reg_t  reg_idx;
		int        val;
		bit        start;
		int        typed_n;
		int        tx;
		int        ty;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata;   // [7:0] bitmap_byte
	logic                 s_axis_tuser;   // [0] glyph_start
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // [11:0] pixel_x, [23:12] pixel_y
	logic                 m_axis_tlast;   // last_of_byte

	glyph_bitmap_to_pixel_writes_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Pixel writes still owed by the block, oldest first.
	pixel_t pending_pix[$];
	pixel_t byte_pix[8];

	// Shadow of the glyph box registers and of the bitmap walk.
	depth_t sh_depth;
	int     sh_left, sh_right_end, sh_top, sh_bottom_end, sh_pitch;
	int     walk_row, walk_col;
	bit     walk_done;
	bit     byte_drawn;

	int send_idle, recv_idle;
	int err_count, bytes_sent, bytes_drawn, pix_seen, glyphs, reg_writes;
	int cycle_cnt;
	pixel_t head_pix;

	dir_row_t dir_tab [26] = '{
		// out of reset the walk is idle, and a glyph start meets an empty box
		'{ROW_BYTE, REG_DEPTH_MODE, 'hFF, 1'b0, 0, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'hFF, 1'b1, 0, 0, 0},
		// box in the bottom right screen corner, right end saturates
		'{ROW_CFG, REG_BOX_RIGHT_END, 8191, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_BOX_BOTTOM_END, 4096, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_BOX_LEFT, 4088, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_BOX_TOP, 4094, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h80, 1'b1, 1, 4088, 4094},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h01, 1'b0, 1, 4095, 4095},
		// past the last row: dropped
		'{ROW_BYTE, REG_DEPTH_MODE, 'hFF, 1'b0, 0, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'hFF, 1'b1, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h00, 1'b0, NO_TYPED, 0, 0},
		// zero pitch behaves as one byte per row; wide box, only 8 columns drawn
		'{ROW_CFG, REG_ROW_PITCH, 0, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_BOX_LEFT, 0, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'hA5, 1'b1, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h5A, 1'b0, NO_TYPED, 0, 0},
		// byte per pixel: zero byte is background
		'{ROW_CFG, REG_ROW_PITCH, 1023, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_DEPTH_MODE, DEPTH_8BPP, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h00, 1'b1, 0, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'hFF, 1'b0, 1, 1, 4094},
		// reprogram mid glyph: column index carries over into bit mode
		'{ROW_CFG, REG_BOX_TOP, 0, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_DEPTH_MODE, DEPTH_1BPP, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'hC3, 1'b0, NO_TYPED, 0, 0},
		// row length and row count already passed: glyph ends after next byte
		'{ROW_CFG, REG_ROW_PITCH, 2, 1'b0, NO_TYPED, 0, 0},
		'{ROW_CFG, REG_BOX_BOTTOM_END, 1, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h81, 1'b0, NO_TYPED, 0, 0},
		'{ROW_BYTE, REG_DEPTH_MODE, 'h7F, 1'b0, 0, 0, 0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Saturate the box ends to the screen and report whether anything is left.
	function automatic bit box_open(output int wd, output int ht);
		int r, b;
		r  = (sh_right_end > SCREEN) ? SCREEN : sh_right_end;
		b  = (sh_bottom_end > SCREEN) ? SCREEN : sh_bottom_end;
		wd = r - sh_left;
		ht = b - sh_top;
		return (r > sh_left) && (b > sh_top);
	endfunction

	// Advance one slot; a full row moves down, the last row ends the glyph.
	function automatic void next_slot(int row_len, int ht);
		walk_col = (walk_col + 1) & COL_MASK;
		if (walk_col >= row_len) begin
			walk_col = 0;
			if (walk_row + 1 >= ht)
				walk_done = 1'b1;
			else
				walk_row = (walk_row + 1) & ROW_MASK;
		end
	endfunction

	// Work out the pixel writes one accepted byte causes; fill byte_pix.
	function automatic int blit_byte(logic [7:0] bm, bit st);
		int n, wd, ht, pitch, col, k;
		n = 0;
		byte_drawn = 1'b0;
		if (st) begin
			walk_row  = 0;
			walk_col  = 0;
			walk_done = 1'b0;
		end
		if (walk_done)
			return 0;
		if (!box_open(wd, ht)) begin
			walk_done = 1'b1;
			return 0;
		end
		byte_drawn = 1'b1;
		if (sh_depth == DEPTH_8BPP) begin
			if (bm != 0 && walk_col < wd) begin
				byte_pix[n].x    = CB'((sh_left + walk_col) & CMASK);
				byte_pix[n].y    = CB'((sh_top + walk_row) & CMASK);
				byte_pix[n].last = 1'b0;
				n++;
			end
			next_slot(wd, ht);
		end else begin
			pitch = (sh_pitch == 0) ? 1 : sh_pitch;
			for (k = 0; k < 8; k++) begin
				col = walk_col * 8 + k;
				if (col < wd && bm[7-k]) begin
					byte_pix[n].x    = CB'((sh_left + col) & CMASK);
					byte_pix[n].y    = CB'((sh_top + walk_row) & CMASK);
					byte_pix[n].last = 1'b0;
					n++;
				end
			end
			next_slot(pitch, ht);
		end
		if (n > 0)
			byte_pix[n-1].last = 1'b1;
		return n;
	endfunction

	function automatic int reg_rand(cfg_reg_t r);
		case (r)
			REG_DEPTH_MODE:                        return $urandom_range(1);
			REG_BOX_LEFT, REG_BOX_TOP:             return $urandom_range(4095);
			REG_BOX_RIGHT_END, REG_BOX_BOTTOM_END: return $urandom_range(8191);
			default:                               return $urandom_range(1023);
		endcase
	endfunction

	function automatic logic [7:0] rand_bitmap();
		case ($urandom_range(5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Hold the byte stream until every owed pixel is back, then let the
	// pipeline settle in case the last byte gave nothing.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_pix.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (r)
			REG_DEPTH_MODE:     sh_depth      = depth_t'(v & 1);
			REG_BOX_LEFT:       sh_left       = v & 'hFFF;
			REG_BOX_RIGHT_END:  sh_right_end  = v & 'h1FFF;
			REG_BOX_TOP:        sh_top        = v & 'hFFF;
			REG_BOX_BOTTOM_END: sh_bottom_end = v & 'h1FFF;
			REG_ROW_PITCH:      sh_pitch      = v & 'h3FF;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Offer one byte request, with a random gap first, and queue its pixels
	// once taken. tvalid stays high on return so back-to-back bytes flow.
	task automatic send_byte(logic [7:0] bm, bit st, int typed_n, int tx, int ty);
		int n, i;
		pixel_t p;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bm;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n = blit_byte(bm, st);
		if (typed_n == NO_TYPED) begin
			for (i = 0; i < n; i++)
				pending_pix.push_back(byte_pix[i]);
		end else if (typed_n == 1) begin
			p.x    = CB'(tx);
			p.y    = CB'(ty);
			p.last = 1'b1;
			pending_pix.push_back(p);
		end
		bytes_sent++;
		if (byte_drawn)
			bytes_drawn++;
	endtask

	// One glyph: maybe a fresh box, then a well-formed bitmap with random
	// content; now and then stray bytes, a cut-short bitmap, a register
	// rewrite in the middle, or trailing bytes past the end.
	task automatic run_glyph();
		int w, h, x0, y0, need, wd, ht, nb, mid, i, extra;
		if (glyphs == 0 || $urandom_range(2) != 0) begin
			if ($urandom_range(7) == 0) begin
				for (i = 0; i < 6; i++)
					write_reg(cfg_reg_t'(i), reg_rand(cfg_reg_t'(i)));
			end else begin
				if ($urandom_range(1) != 0) begin
					w = $urandom_range(8, 1);
					h = $urandom_range(4, 1);
					write_reg(REG_DEPTH_MODE, DEPTH_8BPP);
				end else begin
					w = $urandom_range(24, 1);
					h = $urandom_range(5, 1);
					write_reg(REG_DEPTH_MODE, DEPTH_1BPP);
				end
				x0 = $urandom_range(SCREEN - w);
				y0 = $urandom_range(SCREEN - h);
				write_reg(REG_BOX_LEFT, x0);
				write_reg(REG_BOX_RIGHT_END, x0 + w);
				write_reg(REG_BOX_TOP, y0);
				write_reg(REG_BOX_BOTTOM_END, y0 + h);
				need = (w + 7) / 8;
				case ($urandom_range(5))
					0:       write_reg(REG_ROW_PITCH, 0);
					1:       write_reg(REG_ROW_PITCH, need - 1);
					2:       write_reg(REG_ROW_PITCH, need + 1);
					default: write_reg(REG_ROW_PITCH, need);
				endcase
			end
		end
		glyphs++;
		if (box_open(wd, ht))
			nb = (sh_depth == DEPTH_8BPP) ? wd * ht : ((sh_pitch == 0) ? 1 : sh_pitch) * ht;
		else
			nb = $urandom_range(2, 1);
		if (nb > 32)
			nb = $urandom_range(32, 1);
		if ($urandom_range(7) == 0)
			nb = $urandom_range(nb, 1);
		mid = ($urandom_range(9) == 0) ? $urandom_range(nb - 1) : -1;
		if ($urandom_range(5) == 0) begin
			extra = $urandom_range(2, 1);
			for (i = 0; i < extra; i++)
				send_byte(rand_bitmap(), 1'b0, NO_TYPED, 0, 0);
		end
		for (i = 0; i < nb; i++) begin
			if (i == mid)
				write_reg(cfg_reg_t'($urandom_range(5)), reg_rand(cfg_reg_t'($urandom_range(5))));
			send_byte(rand_bitmap(), i == 0, NO_TYPED, 0, 0);
		end
		if ($urandom_range(3) == 0) begin
			extra = $urandom_range(3, 1);
			for (i = 0; i < extra; i++)
				send_byte(rand_bitmap(), 1'b0, NO_TYPED, 0, 0);
		end
	endtask

	// Stall the pixel port at random, at the rate of the current phase.
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Compare each pixel request taken with the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pix_seen++;
			if (pending_pix.size() == 0) begin
				err_count++;
				$display("%0t: unexpected pixel: expected none, got x=%0d y=%0d last=%0b",
					$time, m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB], m_axis_tlast);
			end else begin
				head_pix = pending_pix.pop_front();
				if (m_axis_tdata[CB-1:0] !== head_pix.x ||
						m_axis_tdata[2*CB-1:CB] !== head_pix.y ||
						m_axis_tlast !== head_pix.last) begin
					err_count++;
					$display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
						$time, head_pix.x, head_pix.y, head_pix.last,
						m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB], m_axis_tlast);
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int i, phase, phase_base;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_DEPTH_MODE;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		send_idle     = 32;
		recv_idle     = 79;
		err_count     = 0;
		bytes_sent    = 0;
		bytes_drawn   = 0;
		pix_seen      = 0;
		glyphs        = 0;
		reg_writes    = 0;
		// reset state of the shadow
		sh_depth      = DEPTH_1BPP;
		sh_left       = 0;
		sh_right_end  = 0;
		sh_top        = 0;
		sh_bottom_end = 0;
		sh_pitch      = 1;
		walk_row      = 0;
		walk_col      = 0;
		walk_done     = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table first.
		for (i = 0; i < $size(dir_tab); i++) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].reg_idx, dir_tab[i].val);
			else
				send_byte(dir_tab[i].val[7:0], dir_tab[i].start, dir_tab[i].typed_n,
					dir_tab[i].tx, dir_tab[i].ty);
		end

		// Random glyphs: slow receiver, then slow sender, then full rate.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 32;
					recv_idle = 79;
				end
				1: begin
					send_idle = 79;
					recv_idle = 32;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			phase_base = bytes_drawn;
			while (bytes_drawn - phase_base < PHASE_BYTES)
				run_glyph();
			// hold off the sender until every pixel of this phase is back
			drain();
		end

		repeat (TAIL) @(posedge clk);
		$display("summary: %0d bitmap bytes sent, %0d inside a live glyph, %0d glyphs",
			bytes_sent, bytes_drawn, glyphs);
		$display("summary: %0d pixel writes checked, %0d register writes, %0d mismatches",
			pix_seen, reg_writes, err_count);
		if (err_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
